[rtl/core/tsia_pkg.sv]
package tsia_pkg;

    // Sizing of the slot pools
    localparam int MAX_SLOTS  = 1024;
    localparam int NUM_TYPES  = 10;

    // Fixed field widths of the channels
    localparam int CMD_W      = 1;
    localparam int TYPE_FW    = 4;
    localparam int SLOT_FW    = 11;
    localparam int GIVEN_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 11;

    // Derived storage widths
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int TYPE_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int CAP_W      = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W     = TYPE_W + IDX_W;
    localparam int STORE_ROWS = NUM_TYPES * (2 ** IDX_W);

    // Fixed capacities of the non-texture types
    localparam int TEXTURE_TYPE     = 0;
    localparam int SAMPLER_TYPE     = 6;
    localparam int SAMPLER_CAPACITY = 8;
    localparam int BUFFER_CAPACITY  = 1;
    localparam logic [CFG_W-1:0] TEXTURE_CAP_RESET = CFG_W'(1024);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TYPE_FW-1:0] resource_type;
        logic [SLOT_FW-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [GIVEN_W-1:0]  given_index;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // Slot capacity of a type; out-of-range types have none
    function automatic logic [CAP_W-1:0] capacity_of(
        input logic [TYPE_FW-1:0] rtype,
        input logic [CFG_W-1:0]   tex_cap
    );
        logic [CAP_W-1:0] cap;
        cap = '0;
        if (rtype >= TYPE_FW'(NUM_TYPES) && NUM_TYPES < (2 ** TYPE_FW)) begin
            cap = '0;
        end else if (rtype == TYPE_FW'(TEXTURE_TYPE)) begin
            if (32'(tex_cap) > MAX_SLOTS) begin
                cap = CAP_W'(MAX_SLOTS);
            end else begin
                cap = CAP_W'(tex_cap);
            end
        end else if (rtype == TYPE_FW'(SAMPLER_TYPE)) begin
            cap = CAP_W'(SAMPLER_CAPACITY);
        end else begin
            cap = CAP_W'(BUFFER_CAPACITY);
        end
        return cap;
    endfunction

endpackage

[rtl/core/tsia_ram.sv]
module tsia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/typed_slot_index_allocator_unit.sv]
// Channel   Direction  Handshake           Payload
// ------    ---------  ------------------  --------------------------------------
// in        input      i_in_valid/o_in_stall    i_in_data  (command, type, slot)
// out       output     o_out_valid/i_out_stall  o_out_data (given_index, status)
// cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_data (texture capacity)
//
// Each item passes through S_IDLE and S_EXEC: the transfer in S_IDLE launches the stack and bitmap
// reads, S_EXEC updates the pointers and memories through the shared
// step unit and loads the output register. The registered read of the memories
// is why S_EXEC is needed. A stalled output holds the item in S_EXEC, and no new item is taken until it completes.
// After reset the membership bitmap is cleared one entry a cycle, all
// NUM_TYPES * 1024 = 10240 entries, during which no input is taken.
module typed_slot_index_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tsia_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tsia_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsia_pkg::CFG_W-1:0]  i_cfg_data
);

    tsia_pkg::t_state                   r_state, n_state;
    tsia_pkg::t_in_item                 r_item;
    logic [tsia_pkg::CFG_W-1:0]         r_tex_cap;
    logic [tsia_pkg::CAP_W-1:0]         r_bump  [tsia_pkg::NUM_TYPES];
    logic [tsia_pkg::CAP_W-1:0]         r_depth [tsia_pkg::NUM_TYPES];
    logic [tsia_pkg::ADDR_W-1:0]        r_clr_addr;
    logic                               r_out_valid;
    tsia_pkg::t_out_item                r_out, n_out;

    tsia_pkg::t_in_item                 cur;
    logic                               type_ok;
    logic [tsia_pkg::TYPE_W-1:0]        sel_type;
    logic [tsia_pkg::CAP_W-1:0]         cap, bump_sel, depth_sel;
    logic [tsia_pkg::CAP_W-1:0]         depth_dec;
    logic                               in_xfer, out_free, exec_go;

    logic [tsia_pkg::IDX_W-1:0]         stk_rdata;
    logic                               bit_rdata;
    logic                               stk_we;
    logic [tsia_pkg::ADDR_W-1:0]        stk_raddr, stk_waddr, bit_raddr, bit_waddr;
    logic                               bit_we, bit_wdata;

    logic                               do_pop, do_bump, do_push;
    logic                               step_use_bump, step_dec;
    logic [tsia_pkg::CAP_W-1:0]         step_a, step_y;

    // Handshakes
    assign in_xfer     = i_in_valid && (r_state == tsia_pkg::S_IDLE);
    assign o_in_stall  = (r_state != tsia_pkg::S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign exec_go     = (r_state == tsia_pkg::S_EXEC) && out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Take the arriving item while idle, the held item otherwise
    assign cur      = (r_state == tsia_pkg::S_IDLE) ? i_in_data : r_item;
    assign type_ok  = (32'(cur.resource_type) < tsia_pkg::NUM_TYPES);
    assign sel_type = cur.resource_type[tsia_pkg::TYPE_W-1:0];
    assign cap      = tsia_pkg::capacity_of(cur.resource_type, r_tex_cap);
    assign bump_sel  = type_ok ? r_bump[sel_type]  : '0;
    assign depth_sel = type_ok ? r_depth[sel_type] : '0;
    assign depth_dec = depth_sel - tsia_pkg::CAP_W'(1);

    // Memory read addresses: top of the stack and the slot's bitmap entry
    assign stk_raddr = {sel_type, depth_dec[tsia_pkg::IDX_W-1:0]};
    assign bit_raddr = {sel_type, cur.slot_index[tsia_pkg::IDX_W-1:0]};

    // Decide the operation from the read data
    always_comb begin
        do_pop  = 1'b0;
        do_bump = 1'b0;
        do_push = 1'b0;
        n_out   = '0;
        n_out.status = tsia_pkg::ST_DONE;
        if (cur.command == tsia_pkg::CMD_ALLOC) begin
            if (cap == '0) begin
                n_out.status = tsia_pkg::ST_OVERFLOW;
            end else if (depth_sel != '0) begin
                do_pop = 1'b1;
                n_out.given_index = tsia_pkg::GIVEN_W'(stk_rdata);
            end else if (bump_sel >= cap) begin
                n_out.status = tsia_pkg::ST_OVERFLOW;
            end else begin
                do_bump = 1'b1;
                n_out.given_index = tsia_pkg::GIVEN_W'(bump_sel);
            end
        end else begin
            if (32'(cur.slot_index) >= 32'(cap)) begin
                n_out.status = tsia_pkg::ST_RANGE;
            end else if (bit_rdata || (32'(depth_sel) >= tsia_pkg::MAX_SLOTS)) begin
                n_out.status = tsia_pkg::ST_DUPLICATE;
            end else begin
                do_push = 1'b1;
            end
        end
    end

    // Shared step unit: advance the bump pointer, grow or shrink the stack
    assign step_use_bump = do_bump;
    assign step_dec      = do_pop;
    assign step_a        = step_use_bump ? bump_sel : depth_sel;
    assign step_y        = step_dec ? (step_a - tsia_pkg::CAP_W'(1))
                                    : (step_a + tsia_pkg::CAP_W'(1));

    // Memory writes: clearing sweep, push, or drop of a popped slot's bit
    assign stk_we    = exec_go && do_push;
    assign stk_waddr = {sel_type, depth_sel[tsia_pkg::IDX_W-1:0]};

    always_comb begin
        bit_we    = 1'b0;
        bit_waddr = r_clr_addr;
        bit_wdata = 1'b0;
        if (r_state == tsia_pkg::S_CLEAR) begin
            bit_we = 1'b1;
        end else if (exec_go && do_pop) begin
            bit_we    = 1'b1;
            bit_waddr = {sel_type, stk_rdata};
        end else if (exec_go && do_push) begin
            bit_we    = 1'b1;
            bit_waddr = bit_raddr;
            bit_wdata = 1'b1;
        end
    end

    tsia_ram #(
        .WIDTH (tsia_pkg::IDX_W),
        .DEPTH (tsia_pkg::STORE_ROWS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (cur.slot_index[tsia_pkg::IDX_W-1:0]),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    tsia_ram #(
        .WIDTH (1),
        .DEPTH (tsia_pkg::STORE_ROWS)
    ) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (bit_we),
        .i_waddr (bit_waddr),
        .i_wdata (bit_wdata),
        .i_raddr (bit_raddr),
        .o_rdata (bit_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsia_pkg::S_CLEAR: begin
                if (r_clr_addr == tsia_pkg::ADDR_W'(tsia_pkg::STORE_ROWS - 1)) begin
                    n_state = tsia_pkg::S_IDLE;
                end
            end
            tsia_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = tsia_pkg::S_EXEC;
                end
            end
            tsia_pkg::S_EXEC: begin
                if (exec_go) begin
                    n_state = tsia_pkg::S_IDLE;
                end
            end
            default: n_state = tsia_pkg::S_CLEAR;
        endcase
    end

    // Control state, pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsia_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_tex_cap   <= tsia_pkg::TEXTURE_CAP_RESET;
            for (int t = 0; t < tsia_pkg::NUM_TYPES; t++) begin
                r_bump[t]  <= '0;
                r_depth[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == tsia_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + tsia_pkg::ADDR_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_tex_cap <= i_cfg_data;
            end
            // Drop the output once taken, load it when an item completes
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (exec_go && do_bump) begin
                r_bump[sel_type] <= step_y;
            end
            if (exec_go && (do_pop || do_push)) begin
                r_depth[sel_type] <= step_y;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        if (exec_go) begin
            r_out <= n_out;
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 40000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 140;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    tsia_pkg::t_in_item            in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    tsia_pkg::t_out_item           out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tsia_pkg::CFG_W-1:0]    cfg_data = '0;

    // Predicted allocator state
    logic [tsia_pkg::CFG_W-1:0]    tex_cap_model = tsia_pkg::TEXTURE_CAP_RESET;
    bit [tsia_pkg::CAP_W-1:0]      pool_bump [tsia_pkg::NUM_TYPES];
    bit [tsia_pkg::CAP_W-1:0]      pool_depth [tsia_pkg::NUM_TYPES];
    bit [tsia_pkg::GIVEN_W-1:0]    pool_stack [tsia_pkg::STORE_ROWS];
    bit                            pool_member [tsia_pkg::STORE_ROWS];

    tsia_pkg::t_in_item            request_q [$];
    tsia_pkg::t_out_item           reply_q [$];

    int                            mismatches = 0;
    int                            send_gap = 0;
    int                            stall_left = 0;
    int                            hold_left = 0;
    int                            quiet_cycles = 0;
    bit                            hold_req = 1'b0;
    bit                            calm = 1'b0;

    typed_slot_index_allocator_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Slots available to one type under a given texture setting
    function automatic int unsigned pool_capacity(logic [tsia_pkg::TYPE_FW-1:0] rtype,
                                                  logic [tsia_pkg::CFG_W-1:0] tex);
        if (32'(rtype) >= tsia_pkg::NUM_TYPES) return 0;
        if (32'(rtype) == tsia_pkg::TEXTURE_TYPE) begin
            return (32'(tex) > tsia_pkg::MAX_SLOTS) ? tsia_pkg::MAX_SLOTS : 32'(tex);
        end
        if (32'(rtype) == tsia_pkg::SAMPLER_TYPE) return tsia_pkg::SAMPLER_CAPACITY;
        return tsia_pkg::BUFFER_CAPACITY;
    endfunction

    // Apply one command to the predicted pools and return the expected reply
    function automatic tsia_pkg::t_out_item slot_pool_step(tsia_pkg::t_in_item req);
        tsia_pkg::t_out_item res;
        int unsigned         cap;
        int unsigned         rt;
        int unsigned         row;
        rt = 32'(req.resource_type);
        cap = pool_capacity(req.resource_type, tex_cap_model);
        res.given_index = '0;
        res.status = tsia_pkg::ST_DONE;
        if (req.command == tsia_pkg::CMD_ALLOC) begin
            if (cap == 0) begin
                res.status = tsia_pkg::ST_OVERFLOW;
            end else if (pool_depth[rt] > 0) begin
                // reuse the most recently freed slot
                pool_depth[rt] = pool_depth[rt] - tsia_pkg::CAP_W'(1);
                row = rt * tsia_pkg::MAX_SLOTS + 32'(pool_depth[rt]);
                res.given_index = pool_stack[row];
                pool_member[rt * tsia_pkg::MAX_SLOTS + 32'(pool_stack[row])] = 1'b0;
            end else if (32'(pool_bump[rt]) >= cap) begin
                res.status = tsia_pkg::ST_OVERFLOW;
            end else begin
                res.given_index = pool_bump[rt][tsia_pkg::GIVEN_W-1:0];
                pool_bump[rt] = pool_bump[rt] + tsia_pkg::CAP_W'(1);
            end
        end else begin
            if (32'(req.slot_index) >= cap) begin
                res.status = tsia_pkg::ST_RANGE;
            end else begin
                row = rt * tsia_pkg::MAX_SLOTS + 32'(req.slot_index);
                if (pool_member[row] || 32'(pool_depth[rt]) >= tsia_pkg::MAX_SLOTS) begin
                    res.status = tsia_pkg::ST_DUPLICATE;
                end else begin
                    pool_stack[rt * tsia_pkg::MAX_SLOTS + 32'(pool_depth[rt])] =
                        req.slot_index[tsia_pkg::GIVEN_W-1:0];
                    pool_depth[rt] = pool_depth[rt] + tsia_pkg::CAP_W'(1);
                    pool_member[row] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Random command, biased towards slots that are likely to be in use
    function automatic tsia_pkg::t_in_item random_request();
        tsia_pkg::t_in_item req;
        int unsigned        r;
        int unsigned        cap;
        int unsigned        span;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            req.resource_type =
                tsia_pkg::TYPE_FW'($urandom_range(tsia_pkg::NUM_TYPES, 15));
        end else if (r < 45) begin
            req.resource_type = tsia_pkg::TYPE_FW'(tsia_pkg::TEXTURE_TYPE);
        end else if (r < 65) begin
            req.resource_type = tsia_pkg::TYPE_FW'(tsia_pkg::SAMPLER_TYPE);
        end else begin
            req.resource_type =
                tsia_pkg::TYPE_FW'($urandom_range(1, tsia_pkg::NUM_TYPES - 1));
        end
        req.command = ($urandom_range(0, 99) < 55) ? tsia_pkg::CMD_ALLOC : tsia_pkg::CMD_FREE;
        req.slot_index = tsia_pkg::SLOT_FW'($urandom_range(0, 2047));
        if (req.command == tsia_pkg::CMD_FREE) begin
            cap = pool_capacity(req.resource_type, tex_cap_model);
            span = (cap == 0) ? 4 : ((cap < 48) ? cap : 48);
            r = $urandom_range(0, 99);
            if (r >= 15) begin
                req.slot_index = tsia_pkg::SLOT_FW'($urandom_range(0, span - 1));
            end else if (r >= 10) begin
                req.slot_index = tsia_pkg::SLOT_FW'(cap);
            end
        end
        return req;
    endfunction

    task automatic push_request(logic [tsia_pkg::CMD_W-1:0] cmd, int rtype, int slot);
        tsia_pkg::t_in_item req;
        req.command = cmd;
        req.resource_type = tsia_pkg::TYPE_FW'(rtype);
        req.slot_index = tsia_pkg::SLOT_FW'(slot);
        request_q.insert(request_q.size(), req);
    endtask

    // Write the texture capacity and wait for the transfer
    task automatic program_capacity(logic [tsia_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        tex_cap_model = value;
        @(negedge clk);
    endtask

    // Hold until every queued command has gone through and been answered
    task automatic wait_drained();
        do @(negedge clk);
        while (request_q.size() != 0 || in_valid || reply_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Sender: offer queued commands with random gaps
    always @(posedge clk) begin
        logic               take;
        logic               next_valid;
        tsia_pkg::t_in_item next_data;
        take = rst_n && in_valid && !in_stall;
        if (take) begin
            reply_q.insert(reply_q.size(), slot_pool_step(in_data));
        end
        next_valid = in_valid && !take;
        next_data = in_data;
        if (rst_n && !next_valid) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(0, 12);
            end else if (request_q.size() > 0) begin
                next_valid = 1'b1;
                next_data = request_q.pop_front();
            end
        end
        in_valid <= next_valid;
        in_data <= next_data;
    end

    // Receiver: check each transfer and stall in random bursts
    always @(posedge clk) begin
        tsia_pkg::t_out_item want;
        logic                next_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (reply_q.size() == 0) begin
                $error("unexpected result: given_index %0d, status %0d",
                       out_data.given_index, out_data.status);
                mismatches++;
            end else begin
                want = reply_q.pop_front();
                if (out_data.given_index !== want.given_index) begin
                    $error("given_index mismatch: expected %0d, actual %0d",
                           want.given_index, out_data.given_index);
                    mismatches++;
                end
                if (out_data.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_data.status);
                    mismatches++;
                end
            end
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            next_stall = 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            next_stall = 1'b1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 12);
            next_stall = 1'b1;
        end else begin
            next_stall = 1'b0;
        end
        out_stall <= next_stall;
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [tsia_pkg::CFG_W-1:0] phase_caps [7];
        phase_caps = '{11'd2047, 11'd3, 11'd0, 11'd1, 11'd1024, 11'd0, 11'd2};
        phase_caps[5] = tsia_pkg::CFG_W'($urandom_range(4, 40));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: texture pool at its reset capacity
        push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::TEXTURE_TYPE, 0);
        push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::TEXTURE_TYPE, 2047);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::TEXTURE_TYPE, 1);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::TEXTURE_TYPE, 1);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::TEXTURE_TYPE, 1023);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::TEXTURE_TYPE, 1024);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::TEXTURE_TYPE, 2047);
        push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::TEXTURE_TYPE, 0);
        push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::TEXTURE_TYPE, 0);
        // exhaust the sampler pool, then one past it
        repeat (9) push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::SAMPLER_TYPE, 0);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::SAMPLER_TYPE, 8);
        push_request(tsia_pkg::CMD_FREE, tsia_pkg::SAMPLER_TYPE, 7);
        // single-slot pool, duplicate free, unknown types
        push_request(tsia_pkg::CMD_ALLOC, 1, 0);
        push_request(tsia_pkg::CMD_ALLOC, 1, 0);
        push_request(tsia_pkg::CMD_FREE, 1, 0);
        push_request(tsia_pkg::CMD_FREE, 1, 0);
        push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::NUM_TYPES - 1, 0);
        push_request(tsia_pkg::CMD_ALLOC, 15, 0);
        push_request(tsia_pkg::CMD_FREE, 15, 0);
        push_request(tsia_pkg::CMD_ALLOC, tsia_pkg::NUM_TYPES, 0);
        wait_drained();

        // Random phases across capacity settings, lowered after use too
        foreach (phase_caps[p]) begin
            program_capacity(phase_caps[p]);
            if (p == 0) hold_req = 1'b1;
            if (p == $size(phase_caps) - 1) calm = 1'b1;
            repeat (PHASE_ITEMS) request_q.insert(request_q.size(), random_request());
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/tsia_pkg.sv
rtl/core/tsia_ram.sv
rtl/core/typed_slot_index_allocator_unit.sv
sim/testbench.sv
